### hdl/obis_pkg.sv
// Shared types, constants and saturation helper for the resonator bank inverse.
`timescale 1ns / 1ps

package obis_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W = 9;
    localparam int CHAN_W = 8;
    localparam int ACC_W = 48;
    localparam int SAT_W = 50;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_CHANNELS_DEF = 256;
    localparam int CHAN_LIMIT = 256;

    localparam logic [DATA_W-1:0] INV_TIME_STEP_RST = 32'h0001_0000;
    localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 9'd256;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_TIME_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

    typedef struct packed {
        logic req_type;
        logic [CHAN_W-1:0] channel;
        logic signed [DATA_W-1:0] sample_value;
        logic signed [DATA_W-1:0] inv_scale;
        logic signed [DATA_W-1:0] damping;
        logic signed [DATA_W-1:0] radian_freq;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] frame_sound;
        logic saturated;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic ovf;
    } sat_t;

    typedef struct packed {
        logic done;
        logic neg;
        logic [ACC_W-1:0] quot;
    } div_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_X,
        ST_XR,
        ST_DIFF,
        ST_WX,
        ST_V,
        ST_T,
        ST_DV,
        ST_DRIVE,
        ST_ACC,
        ST_DSTART,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Clamp a wide signed value to 32 bits and flag whether it was clipped.
    function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
        sat_t r;
        r.ovf = !((&v[SAT_W-1:DATA_W-1]) || (~|v[SAT_W-1:DATA_W-1]));
        if (r.ovf)
        begin
            r.val = v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/obis_mul.sv
// Shared Q16.16 multiplier: registered product, floor shift and 32-bit saturation.
`timescale 1ns / 1ps

module obis_mul (
    input  logic clk,
    input  logic signed [obis_pkg::DATA_W-1:0] op_a,
    input  logic signed [obis_pkg::DATA_W:0] op_b,
    output obis_pkg::sat_t res
);

    localparam int PROD_W = 2 * obis_pkg::DATA_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-17:0] shifted;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // An arithmetic shift rounds toward minus infinity, as the format requires.
    assign shifted = prod_reg[PROD_W-1:16];
    assign res = obis_pkg::sat32(obis_pkg::SAT_W'(shifted));

endmodule

### hdl/obis_div.sv
// Bit-serial restoring divider for the frame average, one quotient bit per cycle.
`timescale 1ns / 1ps

module obis_div (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [obis_pkg::ACC_W-1:0] dividend,
    input  logic [obis_pkg::CNT_W-1:0] divisor,
    output obis_pkg::div_res_t res
);

    localparam int ACC_W = obis_pkg::ACC_W;
    localparam int CNT_W = obis_pkg::CNT_W;
    localparam int STEP_W = $clog2(ACC_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ACC_W - 1);

    logic busy_reg;
    logic busy_next;
    logic done_reg;
    logic done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic [ACC_W-1:0] mag_reg;
    logic [ACC_W-1:0] mag_next;
    logic neg_reg;
    logic neg_next;
    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] rem_diff;
    logic fits;

    assign rem_sh = {rem_reg, mag_reg[ACC_W-1]};
    assign rem_diff = rem_sh - {1'b0, divisor};
    assign fits = rem_sh >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next = rem_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next = '0;
            neg_next = dividend[ACC_W-1];
            mag_next = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits the narrow register.
            rem_next = fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            mag_next = {mag_reg[ACC_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    assign res.done = done_reg;
    assign res.neg = neg_reg;
    assign res.quot = mag_reg;

endmodule

### hdl/oscillator_bank_inverse_synth.sv
// Top level: sequencer, coefficient and history memories, frame accumulator.
`timescale 1ns / 1ps
// Inverts a bank of damped resonators in Q16.16 arithmetic.
// Items arrive on item_valid/item_ready. A load word stores a channel's scale,
// damping and squared frequency; a sample word updates that channel's history
// and adds its drive to the frame sum. Results leave on result_valid/
// result_ready, one word per frame, on the sample of the last channel.
// Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high, and writes belong in idle periods.
// A load passes through a multiply state and a write state, a sample through
// the states ST_X to ST_ACC, and a sample on a channel at or above the count is
// dropped in idle. All products go one at a time through a single shared
// multiplier, six of them per sample. The last channel then adds a start state,
// a 48-step serial division, a wait state that sees it finish, and an emit state
// that writes the result register; the next word is taken after that.
// item_ready is high only while the sequencer is idle.
// A finished result waits in the output register; a new one is held back only
// if the previous one has still not been taken at the end of the next frame.
// Reset clears the history (through per-channel valid bits), the frame sum and
// the saturation flag, and restores the registers; coefficients stay unknown.

module oscillator_bank_inverse_synth #(
    parameter int MAX_CHANNELS = obis_pkg::MAX_CHANNELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  obis_pkg::item_t item,
    output logic result_valid,
    input  logic result_ready,
    output obis_pkg::result_t result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [obis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [obis_pkg::DATA_W-1:0] cfg_data
);

    localparam int DATA_W = obis_pkg::DATA_W;
    localparam int CNT_W = obis_pkg::CNT_W;
    localparam int ACC_W = obis_pkg::ACC_W;
    localparam int SAT_W = obis_pkg::SAT_W;
    localparam int DEPTH = (MAX_CHANNELS < obis_pkg::CHAN_LIMIT) ? MAX_CHANNELS
                                                                 : obis_pkg::CHAN_LIMIT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(DEPTH);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(64'h8000_0000);

    typedef struct packed {
        logic signed [DATA_W-1:0] scale;
        logic signed [DATA_W-1:0] damping;
        logic signed [DATA_W-1:0] freq_sq;
    } coef_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prev;
        logic signed [DATA_W-1:0] prev2;
    } hist_t;

    coef_t coef_mem [DEPTH];
    hist_t disp_mem [DEPTH];

    obis_pkg::state_t state_reg;
    obis_pkg::state_t state_next;
    obis_pkg::item_t item_reg;
    obis_pkg::item_t item_next;
    obis_pkg::result_t out_reg;
    obis_pkg::result_t out_next;
    obis_pkg::sat_t mul_res;
    obis_pkg::sat_t d1_sat;
    obis_pkg::sat_t d2_sat;
    obis_pkg::sat_t drive_sat;
    obis_pkg::div_res_t div_res;

    coef_t coef_rd_reg;
    hist_t disp_rd_reg;
    logic vld_rd_reg;
    logic [DEPTH-1:0] disp_vld_reg;

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] x_next;
    logic signed [DATA_W-1:0] d1_reg;
    logic signed [DATA_W-1:0] d1_next;
    logic signed [DATA_W-1:0] d2_reg;
    logic signed [DATA_W-1:0] d2_next;
    logic signed [DATA_W-1:0] wx_reg;
    logic signed [DATA_W-1:0] wx_next;
    logic signed [DATA_W-1:0] v_reg;
    logic signed [DATA_W-1:0] v_next;
    logic signed [DATA_W-1:0] t_reg;
    logic signed [DATA_W-1:0] t_next;
    logic signed [DATA_W-1:0] dv_reg;
    logic signed [DATA_W-1:0] dv_next;
    logic signed [DATA_W-1:0] drive_reg;
    logic signed [DATA_W-1:0] drive_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic sat_reg;
    logic sat_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic [DATA_W-1:0] idt_reg;
    logic [DATA_W-1:0] idt_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W:0] op_b;
    logic signed [DATA_W:0] idt_op;
    logic signed [DATA_W-1:0] p1;
    logic signed [DATA_W-1:0] p2;
    logic signed [SAT_W-1:0] d1_sum;
    logic signed [SAT_W-1:0] d2_sum;
    logic signed [SAT_W-1:0] drive_sum;
    logic signed [ACC_W:0] acc_sum;
    logic acc_ovf;
    logic [CNT_W-1:0] cnt_eff;
    logic is_last;
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic coef_we;
    logic disp_we;
    logic div_start;
    logic emit_go;
    logic avg_ovf;
    logic signed [DATA_W-1:0] avg_val;

    obis_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .res  (mul_res)
    );

    obis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (cnt_eff),
        .res      (div_res)
    );

    assign item_ready = (state_reg == obis_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = out_valid_reg;
    assign result = out_reg;

    // A count of zero behaves as one channel, and counts past the memory depth clip to it.
    assign cnt_eff = (cnt_reg == '0) ? CNT_W'(1) : ((cnt_reg > DEPTH_V) ? DEPTH_V : cnt_reg);
    assign is_last = ({1'b0, item_reg.channel} == (cnt_eff - CNT_W'(1)));

    assign rd_en = item_valid && item_ready;
    assign rd_addr = item.channel[ADDR_W-1:0];
    assign wr_addr = item_reg.channel[ADDR_W-1:0];

    // History of a channel never sampled since reset reads as zero.
    assign p1 = vld_rd_reg ? disp_rd_reg.prev : '0;
    assign p2 = vld_rd_reg ? disp_rd_reg.prev2 : '0;
    assign idt_op = {1'b0, idt_reg};

    assign d1_sum = SAT_W'(x_reg) - SAT_W'(p1);
    assign d2_sum = SAT_W'(x_reg) - (SAT_W'(p1) <<< 1) + SAT_W'(p2);
    assign drive_sum = SAT_W'(mul_res.val) + SAT_W'(dv_reg) + SAT_W'(wx_reg);
    assign d1_sat = obis_pkg::sat32(d1_sum);
    assign d2_sat = obis_pkg::sat32(d2_sum);
    assign drive_sat = obis_pkg::sat32(drive_sum);

    assign acc_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(drive_reg);
    assign acc_ovf = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];

    assign emit_go = !out_valid_reg || result_ready;

    // The divider works on magnitudes; the sign and the 32-bit clamp are applied here.
    always_comb
    begin
        if (div_res.neg)
        begin
            avg_ovf = div_res.quot > NEG_LIMIT;
            avg_val = avg_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : -div_res.quot[DATA_W-1:0];
        end
        else
        begin
            avg_ovf = |div_res.quot[ACC_W-1:DATA_W-1];
            avg_val = avg_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : div_res.quot[DATA_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        x_next = x_reg;
        d1_next = d1_reg;
        d2_next = d2_reg;
        wx_next = wx_reg;
        v_next = v_reg;
        t_next = t_reg;
        dv_next = dv_reg;
        drive_next = drive_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        idt_next = idt_reg;
        cnt_next = cnt_reg;
        op_a = '0;
        op_b = '0;
        coef_we = 1'b0;
        disp_we = 1'b0;
        div_start = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                obis_pkg::CFG_INV_TIME_STEP: idt_next = cfg_data;
                obis_pkg::CFG_CHANNEL_COUNT: cnt_next = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            obis_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    if (item.req_type == obis_pkg::REQ_LOAD)
                    begin
                        if ({1'b0, item.channel} < DEPTH_V)
                        begin
                            state_next = obis_pkg::ST_LD_MUL;
                        end
                    end
                    else if ({1'b0, item.channel} < cnt_eff)
                    begin
                        state_next = obis_pkg::ST_X;
                    end
                end
            end
            obis_pkg::ST_LD_MUL:
            begin
                op_a = item_reg.radian_freq;
                op_b = (DATA_W + 1)'(item_reg.radian_freq);
                state_next = obis_pkg::ST_LD_WR;
            end
            obis_pkg::ST_LD_WR:
            begin
                coef_we = 1'b1;
                sat_next = sat_reg | mul_res.ovf;
                state_next = obis_pkg::ST_IDLE;
            end
            obis_pkg::ST_X:
            begin
                op_a = item_reg.sample_value;
                op_b = (DATA_W + 1)'(coef_rd_reg.scale);
                state_next = obis_pkg::ST_XR;
            end
            obis_pkg::ST_XR:
            begin
                x_next = mul_res.val;
                sat_next = sat_reg | mul_res.ovf;
                state_next = obis_pkg::ST_DIFF;
            end
            obis_pkg::ST_DIFF:
            begin
                d1_next = d1_sat.val;
                d2_next = d2_sat.val;
                sat_next = sat_reg | d1_sat.ovf | d2_sat.ovf;
                op_a = coef_rd_reg.freq_sq;
                op_b = (DATA_W + 1)'(x_reg);
                state_next = obis_pkg::ST_WX;
            end
            obis_pkg::ST_WX:
            begin
                wx_next = mul_res.val;
                sat_next = sat_reg | mul_res.ovf;
                op_a = d1_reg;
                op_b = idt_op;
                state_next = obis_pkg::ST_V;
            end
            obis_pkg::ST_V:
            begin
                v_next = mul_res.val;
                sat_next = sat_reg | mul_res.ovf;
                op_a = d2_reg;
                op_b = idt_op;
                state_next = obis_pkg::ST_T;
            end
            obis_pkg::ST_T:
            begin
                t_next = mul_res.val;
                sat_next = sat_reg | mul_res.ovf;
                op_a = coef_rd_reg.damping;
                op_b = (DATA_W + 1)'(v_reg);
                state_next = obis_pkg::ST_DV;
            end
            obis_pkg::ST_DV:
            begin
                dv_next = mul_res.val;
                sat_next = sat_reg | mul_res.ovf;
                op_a = t_reg;
                op_b = idt_op;
                state_next = obis_pkg::ST_DRIVE;
            end
            obis_pkg::ST_DRIVE:
            begin
                // The multiplier now holds the acceleration term.
                drive_next = drive_sat.val;
                sat_next = sat_reg | mul_res.ovf | drive_sat.ovf;
                state_next = obis_pkg::ST_ACC;
            end
            obis_pkg::ST_ACC:
            begin
                disp_we = 1'b1;
                if (acc_ovf)
                begin
                    acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
                end
                else
                begin
                    acc_next = acc_sum[ACC_W-1:0];
                end
                sat_next = sat_reg | acc_ovf;
                state_next = is_last ? obis_pkg::ST_DSTART : obis_pkg::ST_IDLE;
            end
            obis_pkg::ST_DSTART:
            begin
                div_start = 1'b1;
                state_next = obis_pkg::ST_DIV;
            end
            obis_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = obis_pkg::ST_EMIT;
                end
            end
            obis_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_next.frame_sound = avg_val;
                    out_next.saturated = sat_reg | avg_ovf;
                    acc_next = '0;
                    sat_next = 1'b0;
                    state_next = obis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = obis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obis_pkg::ST_IDLE;
            acc_reg <= '0;
            sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idt_reg <= obis_pkg::INV_TIME_STEP_RST;
            cnt_reg <= obis_pkg::CHANNEL_COUNT_RST;
            disp_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            sat_reg <= sat_next;
            out_valid_reg <= out_valid_next;
            idt_reg <= idt_next;
            cnt_reg <= cnt_next;
            if (disp_we)
            begin
                disp_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg <= out_next;
        x_reg <= x_next;
        d1_reg <= d1_next;
        d2_reg <= d2_next;
        wx_reg <= wx_next;
        v_reg <= v_next;
        t_reg <= t_next;
        dv_reg <= dv_next;
        drive_reg <= drive_next;
        if (rd_en)
        begin
            vld_rd_reg <= disp_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[wr_addr] <= '{scale: item_reg.inv_scale,
                                   damping: item_reg.damping,
                                   freq_sq: mul_res.val};
        end
        if (disp_we)
        begin
            disp_mem[wr_addr] <= '{prev: x_reg, prev2: p1};
        end
        if (rd_en)
        begin
            coef_rd_reg <= coef_mem[rd_addr];
            disp_rd_reg <= disp_mem[rd_addr];
        end
    end

endmodule

### hdl/obis_checker.sv
// Port-level checks for the resonator bank inverse, bound to the top level.
`timescale 1ns / 1ps

module obis_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready,
    input obis_pkg::result_t result
);

    // A result word waiting on the receiver keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
        else $error("result word withdrawn without a handshake");

    // A new result is only written from the busy sequencer.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared while the input side was idle");

    // No item can produce its result in the cycle right after acceptance.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !$rose(result_valid))
        else $error("result appeared one cycle after an accepted word");

endmodule

bind oscillator_bank_inverse_synth obis_checker u_obis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

### test/tb_top.sv
// Self-checking testbench for the damped-resonator bank inverse with its own Q16.16 predictor.
`timescale 1ns / 1ps

module tb_top;

    import obis_pkg::*;

    localparam longint Q_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_LO = -64'sh0000_0000_8000_0000;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam int NUM_PHASES = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item_word = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // Predictor state: registers as last written and the block's tables.
    logic [DATA_W-1:0] step_inv = INV_TIME_STEP_RST;
    logic [CNT_W-1:0] chan_count_reg = CHANNEL_COUNT_RST;
    logic signed [DATA_W-1:0] scale_mem [CHAN_LIMIT] = '{default: '0};
    logic signed [DATA_W-1:0] damp_mem [CHAN_LIMIT] = '{default: '0};
    logic signed [DATA_W-1:0] wsq_mem [CHAN_LIMIT] = '{default: '0};
    logic signed [DATA_W-1:0] hist1 [CHAN_LIMIT] = '{default: '0};
    logic signed [DATA_W-1:0] hist2 [CHAN_LIMIT] = '{default: '0};
    longint frame_sum = 0;
    bit frame_sat = 1'b0;

    item_t item_backlog [$];
    result_t frames_due [$];
    bit chan_loaded [CHAN_LIMIT] = '{default: 1'b0};

    int items_queued = 0;
    int items_taken = 0;
    int loads_taken = 0;
    int samples_taken = 0;
    int samples_ignored = 0;
    int frames_checked = 0;
    int sat_frames = 0;
    int settings_used = 0;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    oscillator_bank_inverse_synth dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item_word),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp32(input longint v);
        if (v > Q_HI)
        begin
            frame_sat = 1'b1;
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            frame_sat = 1'b1;
            return Q_LO;
        end
        return v;
    endfunction

    // The arithmetic shift floors, which matches rounding toward minus infinity.
    function automatic longint qmul(input longint a, input longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    function automatic int eff_channels(input logic [CNT_W-1:0] reg_val);
        if (reg_val == 0)
            return 1;
        if (reg_val > CHAN_LIMIT)
            return CHAN_LIMIT;
        return int'(reg_val);
    endfunction

    function automatic void resonator_step(input item_t it);
        int ch;
        int cnt;
        longint idt, x, p1, p2, d1, d2, v, t, accel, drive, sum;
        result_t r;
        ch = int'(it.channel);
        if (it.req_type == REQ_LOAD)
        begin
            scale_mem[ch] = it.inv_scale;
            damp_mem[ch] = it.damping;
            wsq_mem[ch] = 32'(qmul(longint'($signed(it.radian_freq)),
                                   longint'($signed(it.radian_freq))));
            loads_taken++;
            return;
        end
        cnt = eff_channels(chan_count_reg);
        if (ch >= cnt)
        begin
            samples_ignored++;
            return;
        end
        samples_taken++;
        idt = longint'(step_inv);
        x = qmul(longint'($signed(it.sample_value)), longint'(scale_mem[ch]));
        p1 = longint'(hist1[ch]);
        p2 = longint'(hist2[ch]);
        d1 = clamp32(x - p1);
        v = qmul(d1, idt);
        d2 = clamp32(x - 2 * p1 + p2);
        t = qmul(d2, idt);
        accel = qmul(t, idt);
        sum = accel + qmul(longint'(damp_mem[ch]), v) + qmul(longint'(wsq_mem[ch]), x);
        drive = clamp32(sum);
        sum = frame_sum + drive;
        if (sum > ACC_HI)
        begin
            sum = ACC_HI;
            frame_sat = 1'b1;
        end
        if (sum < ACC_LO)
        begin
            sum = ACC_LO;
            frame_sat = 1'b1;
        end
        frame_sum = sum;
        hist2[ch] = hist1[ch];
        hist1[ch] = 32'(x);
        if (ch == cnt - 1)
        begin
            // A clipped average counts as a saturation of this frame.
            r.frame_sound = 32'(clamp32(frame_sum / longint'(cnt)));
            r.saturated = frame_sat;
            frames_due.push_back(r);
            frame_sum = 0;
            frame_sat = 1'b0;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_q16();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
        if (roll < 80)
            return $urandom();
        case ($urandom_range(4))
            0: return 32'sh0000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return 32'shFFFF_FFFF;
            default: return 32'sh0001_0000;
        endcase
    endfunction

    function automatic item_t rand_item(input logic kind, input int ch);
        item_t it;
        it.req_type = kind;
        it.channel = ch[CHAN_W-1:0];
        it.sample_value = pick_q16();
        it.inv_scale = pick_q16();
        it.damping = pick_q16();
        it.radian_freq = pick_q16();
        return it;
    endfunction

    function automatic void push_item(input item_t it);
        item_backlog.push_back(it);
        items_queued++;
        if (it.req_type == REQ_LOAD)
            chan_loaded[it.channel] = 1'b1;
    endfunction

    // Loads the channel first if it has never been given coefficients.
    function automatic int sample_chan(input int ch);
        int added;
        added = 1;
        if (!chan_loaded[ch])
        begin
            push_item(rand_item(REQ_LOAD, ch));
            added++;
        end
        push_item(rand_item(REQ_SAMPLE, ch));
        return added;
    endfunction

    function automatic void gen_phase(input int eff, input int budget);
        int made;
        int roll;
        int ch;
        int n;
        made = 0;
        while (made < budget)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                for (ch = 0; ch < eff; ch++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        push_item(rand_item(REQ_LOAD, $urandom_range(CHAN_LIMIT - 1)));
                        made++;
                    end
                    made += sample_chan(ch);
                end
            end
            else if (roll < 85)
            begin
                if (eff < CHAN_LIMIT && $urandom_range(1) == 1)
                    push_item(rand_item(REQ_SAMPLE, $urandom_range(CHAN_LIMIT - 1, eff)));
                else
                begin
                    push_item(rand_item(REQ_LOAD, $urandom_range(CHAN_LIMIT - 1)));
                    made++;
                end
            end
            else
            begin
                n = $urandom_range(eff, 1);
                repeat (n)
                    made += sample_chan($urandom_range(eff - 1));
            end
        end
        // Close the open frame so the next setting starts from an empty sum.
        made += sample_chan(eff - 1);
    endfunction

    task automatic wait_idle();
        while (items_taken != items_queued || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_INV_TIME_STEP)
            step_inv = value;
        else
            chan_count_reg = value[CNT_W-1:0];
    endtask

    // Sender: predicts each accepted word, then offers the next one unless idling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                resonator_step(item_word);
                items_taken++;
            end
            if (!item_valid || item_ready)
            begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item_word <= item_backlog.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted word against the oldest predicted frame.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result_word);
                end
                else
                begin
                    want = frames_due.pop_front();
                    frames_checked++;
                    if (want.saturated)
                        sat_frames++;
                    if (result_word.frame_sound !== want.frame_sound)
                    begin
                        errors++;
                        $display("%0t: frame_sound mismatch, expected %h, actual %h",
                                 $time, want.frame_sound, result_word.frame_sound);
                    end
                    if (result_word.saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated mismatch, expected %b, actual %b",
                                 $time, want.saturated, result_word.saturated);
                    end
                end
            end
            if (hold_arm && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [DATA_W-1:0] phase_step [NUM_PHASES];
        logic [CNT_W-1:0] phase_count [NUM_PHASES];
        int phase_budget [NUM_PHASES];
        int p;

        phase_step = '{32'h0001_0000, 32'h0000_0001, 32'h0002_0000, 32'hFFFF_FFFF,
                       $urandom(), 32'h0001_0000, 32'h0000_8000,
                       $urandom_range(32'h0004_0000, 1)};
        phase_count = '{9'd1, 9'd0, 9'd3, 9'd5, 9'd8, 9'd511, 9'd2,
                        9'($urandom_range(16, 1))};
        phase_budget = '{200, 200, 200, 200, 200, 600, 200, 200};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 18;
        recv_idle_pct = 83;

        // Directed words: coefficient and sample extremes, load-time saturation of
        // the squared frequency, samples past the channel count, two full frames.
        write_reg(CFG_INV_TIME_STEP, 32'h0001_0000);
        write_reg(CFG_CHANNEL_COUNT, 32'd4);
        settings_used++;
        push_item(item_t'{REQ_LOAD, 8'd0, 32'sh0000_0000, 32'sh0001_0000, 32'sh0000_8000,
                          32'sh0001_0000});
        push_item(item_t'{REQ_LOAD, 8'd1, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sh8000_0000});
        push_item(item_t'{REQ_LOAD, 8'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF});
        push_item(item_t'{REQ_LOAD, 8'd3, 32'sh8000_0000, 32'shFFFF_0000, 32'sh0000_0000,
                          32'sh0000_0000});
        push_item(item_t'{REQ_LOAD, 8'd255, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
                          32'shFFFF_FFFF});
        push_item(item_t'{REQ_SAMPLE, 8'd0, 32'sh0000_0000, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd1, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd2, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd3, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd200, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd0, 32'shFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd1, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd2, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd3, 32'shFFFF_0000, 32'sh0, 32'sh0, 32'sh0});
        push_item(item_t'{REQ_SAMPLE, 8'd255, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0});
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 18;
            end
            if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_INV_TIME_STEP, phase_step[p]);
            write_reg(CFG_CHANNEL_COUNT, {{(DATA_W-CNT_W){1'b0}}, phase_count[p]});
            settings_used++;
            // With one channel per frame every sample makes a result, so a long
            // receiver stall here backs the block up into its input.
            if (p == 0)
                hold_arm = 1'b1;
            gen_phase(eff_channels(phase_count[p]), phase_budget[p]);
            wait_idle();
        end

        $display("Run covered %0d loads and %0d samples (%0d past the count) in %0d settings.",
                 loads_taken, samples_taken, samples_ignored, settings_used);
        $display("Checked %0d frame averages, %0d of them flagged as saturated.",
                 frames_checked, sat_frames);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
